// ===== hw/rtl/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg: shared types for the rotation matrix to quaternion unit
// Branch codes, lane payload and default fixed point setting.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  // default number of fraction bits (1.0 = 2**14)
  localparam int FRACTION_BITS_DEF = 14;

  // width of a lane numerator magnitude (sum of two 16-bit values)
  localparam int LANE_MAG_W = 17;

  // number of quotient lanes
  localparam int NUM_LANES = 3;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } rmq_branch_e;

  // payload that rides along every cell of the chain
  typedef struct packed {
    rmq_branch_e                                branch;
    logic                                       degen;
    logic [NUM_LANES-1:0]                       neg;
    logic [NUM_LANES-1:0][LANE_MAG_W-1:0]       mag;
  } rmq_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front: branch selection and radicand stage
// Picks the branch, forms the radicand and the three lane numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front
  import rmq_pkg::*;
#(
  parameter int FB = FRACTION_BITS_DEF,
  parameter int RT = FB + 9
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire logic signed [15:0] r00_i,
  input  wire logic signed [15:0] r10_i,
  input  wire logic signed [15:0] r20_i,
  input  wire logic signed [15:0] r01_i,
  input  wire logic signed [15:0] r11_i,
  input  wire logic signed [15:0] r21_i,
  input  wire logic signed [15:0] r02_i,
  input  wire logic signed [15:0] r12_i,
  input  wire logic signed [15:0] r22_i,
  output logic                    valid_o,
  output rmq_item_t               item_o,
  output logic [2*RT-1:0]         v_o
);

  localparam int SW   = FB + 19;
  localparam int RADB = SW - 1;

  logic signed [SW-1:0] one_s, e00, e11, e22, trace_s, rad_s;
  logic signed [16:0]   d21m12, d02m20, d10m01, s10p01, s02p20, s21p12;
  logic signed [16:0]   lane [NUM_LANES];
  rmq_branch_e          br;
  rmq_item_t            item_d, item_q;
  logic [2*RT-1:0]      v_d, v_q;
  logic                 valid_q;

  assign one_s = SW'(1) << FB;
  assign e00   = SW'(r00_i);
  assign e11   = SW'(r11_i);
  assign e22   = SW'(r22_i);
  assign trace_s = one_s + e00 + e11 + e22;

  assign d21m12 = 17'(r21_i) - 17'(r12_i);
  assign d02m20 = 17'(r02_i) - 17'(r20_i);
  assign d10m01 = 17'(r10_i) - 17'(r01_i);
  assign s10p01 = 17'(r10_i) + 17'(r01_i);
  assign s02p20 = 17'(r02_i) + 17'(r20_i);
  assign s21p12 = 17'(r21_i) + 17'(r12_i);

  // choose branch, radicand and lanes in order of the non-diagonal slots
  always_comb begin
    priority if (trace_s > 0) begin
      br      = BR_TRACE;
      rad_s   = trace_s;
      lane[0] = d21m12;
      lane[1] = d02m20;
      lane[2] = d10m01;
    end else if (r00_i > r11_i && r00_i > r22_i) begin
      br      = BR_X;
      rad_s   = one_s + e00 - e11 - e22;
      lane[0] = s10p01;
      lane[1] = s02p20;
      lane[2] = d21m12;
    end else if (r11_i > r22_i) begin
      br      = BR_Y;
      rad_s   = one_s + e11 - e00 - e22;
      lane[0] = s10p01;
      lane[1] = s21p12;
      lane[2] = d02m20;
    end else begin
      br      = BR_Z;
      rad_s   = one_s + e22 - e00 - e11;
      lane[0] = s02p20;
      lane[1] = s21p12;
      lane[2] = d10m01;
    end
  end

  // split lanes into sign and magnitude
  always_comb begin
    item_d.branch = br;
    item_d.degen  = rad_s[SW-1] || (rad_s == '0);
    for (int i = 0; i < NUM_LANES; i++) begin
      item_d.neg[i] = lane[i][16];
      item_d.mag[i] = lane[i][16] ? LANE_MAG_W'(-lane[i]) : LANE_MAG_W'(lane[i]);
    end
  end

  assign v_d = {rad_s[RADB-1:0], {FB{1'b0}}};

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // advance payload
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      item_q <= item_d;
      v_q    <= v_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign v_o     = v_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rmq_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt_cell: one digit of the restoring square root
// Takes two radicand bits and resolves one root bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt_cell
  import rmq_pkg::*;
#(
  parameter int RT = FRACTION_BITS_DEF + 9
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire rmq_item_t       item_i,
  input  wire logic [RT+1:0]   rem_i,
  input  wire logic [RT-1:0]   root_i,
  input  wire logic [2*RT-1:0] v_i,
  output logic                 valid_o,
  output rmq_item_t            item_o,
  output logic [RT+1:0]        rem_o,
  output logic [RT-1:0]        root_o,
  output logic [2*RT-1:0]      v_o
);

  logic [RT+1:0]   rem_t, trial, rem_q;
  logic [RT+2:0]   diff;
  logic            ge;
  logic [RT-1:0]   root_q;
  logic [2*RT-1:0] v_q;
  rmq_item_t       item_q;
  logic            valid_q;

  // trial subtract of the next root digit
  assign rem_t = {rem_i[RT-1:0], v_i[2*RT-1 -: 2]};
  assign trial = {root_i, 2'b01};
  assign diff  = {1'b0, rem_t} - {1'b0, trial};
  assign ge    = !diff[RT+2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // advance remainder, root and remaining radicand bits
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      rem_q  <= ge ? diff[RT+1:0] : rem_t;
      root_q <= {root_i[RT-2:0], ge};
      v_q    <= {v_i[2*RT-3:0], 2'b00};
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign v_o     = v_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rmq_div_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_div_cell: one quotient bit of three restoring dividers
// Each lane divides its numerator by twice the root, one bit per cell.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div_cell
  import rmq_pkg::*;
#(
  parameter int RT = FRACTION_BITS_DEF + 9,
  parameter int NB = FRACTION_BITS_DEF + 18
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           en_i,
  input  wire logic                           valid_i,
  input  wire rmq_item_t                      item_i,
  input  wire logic [RT-1:0]                  root_i,
  input  wire logic [NUM_LANES-1:0][RT+1:0]   rem_i,
  input  wire logic [NUM_LANES-1:0][NB-1:0]   n_i,
  input  wire logic [NUM_LANES-1:0][NB-1:0]   q_i,
  output logic                                valid_o,
  output rmq_item_t                           item_o,
  output logic [RT-1:0]                       root_o,
  output logic [NUM_LANES-1:0][RT+1:0]        rem_o,
  output logic [NUM_LANES-1:0][NB-1:0]        n_o,
  output logic [NUM_LANES-1:0][NB-1:0]        q_o
);

  logic [RT+1:0]                 dd;
  logic [NUM_LANES-1:0][RT+1:0]  rem_t, rem_d, rem_q;
  logic [NUM_LANES-1:0][RT+2:0]  diff;
  logic [NUM_LANES-1:0][NB-1:0]  n_d, q_d, n_q, q_q;
  logic [RT-1:0]                 root_q;
  rmq_item_t                     item_q;
  logic                          valid_q;

  assign dd = {1'b0, root_i, 1'b0};

  // shift in the next numerator bit and subtract where it fits
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      rem_t[i] = {rem_i[i][RT:0], n_i[i][NB-1]};
      diff[i]  = {1'b0, rem_t[i]} - {1'b0, dd};
      rem_d[i] = diff[i][RT+2] ? rem_t[i] : diff[i][RT+1:0];
      q_d[i]   = {q_i[i][NB-2:0], !diff[i][RT+2]};
      n_d[i]   = {n_i[i][NB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      rem_q  <= rem_d;
      q_q    <= q_d;
      n_q    <= n_d;
      root_q <= root_i;
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign root_o  = root_q;
  assign rem_o   = rem_q;
  assign n_o     = n_q;
  assign q_o     = q_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rmq_back.sv =====
// ----------------------------------------------------------------------------
// rmq_back: output stage
// Signs and saturates the quotients, places the diagonal term, registers out.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_back
  import rmq_pkg::*;
#(
  parameter int RT = FRACTION_BITS_DEF + 9,
  parameter int NB = FRACTION_BITS_DEF + 18
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire rmq_item_t                     item_i,
  input  wire logic [RT-1:0]                 root_i,
  input  wire logic [NUM_LANES-1:0][NB-1:0]  q_i,
  output logic                               valid_o,
  output logic signed [15:0]                 qx_o,
  output logic signed [15:0]                 qy_o,
  output logic signed [15:0]                 qz_o,
  output logic signed [15:0]                 qw_o,
  output logic [1:0]                         branch_o,
  output logic                               degenerate_o
);

  logic [RT:0]          diag_full;
  logic [15:0]          diag;
  logic [15:0]          lane [NUM_LANES];
  logic [15:0]          qx_d, qy_d, qz_d, qw_d;
  logic [15:0]          qx_q, qy_q, qz_q, qw_q;
  logic [1:0]           branch_q;
  logic                 degen_q, valid_q;

  // round the diagonal term up on halves and clamp
  assign diag_full = ({1'b0, root_i} + (RT+1)'(1)) >> 1;
  assign diag = (diag_full > (RT+1)'(32767)) ? 16'h7fff : diag_full[15:0];

  // apply sign and saturate each quotient
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (item_i.neg[i]) begin
        lane[i] = (q_i[i] > NB'(32768)) ? 16'h8000 : 16'(~q_i[i][15:0] + 16'd1);
      end else begin
        lane[i] = (q_i[i] > NB'(32767)) ? 16'h7fff : q_i[i][15:0];
      end
    end
  end

  // place the diagonal term in the slot of the branch
  always_comb begin
    unique case (item_i.branch)
      BR_TRACE: begin
        qx_d = lane[0]; qy_d = lane[1]; qz_d = lane[2]; qw_d = diag;
      end
      BR_X: begin
        qx_d = diag; qy_d = lane[0]; qz_d = lane[1]; qw_d = lane[2];
      end
      BR_Y: begin
        qx_d = lane[0]; qy_d = diag; qz_d = lane[1]; qw_d = lane[2];
      end
      default: begin
        qx_d = lane[0]; qy_d = lane[1]; qz_d = diag; qw_d = lane[2];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // drop the components of a degenerate radicand
  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      qx_q     <= item_i.degen ? '0 : qx_d;
      qy_q     <= item_i.degen ? '0 : qy_d;
      qz_q     <= item_i.degen ? '0 : qz_d;
      qw_q     <= item_i.degen ? '0 : qw_d;
      branch_q <= item_i.branch;
      degen_q  <= item_i.degen;
    end
  end

  assign valid_o      = valid_q;
  assign qx_o         = qx_q;
  assign qy_o         = qy_q;
  assign qz_o         = qz_q;
  assign qw_o         = qw_q;
  assign branch_o     = branch_q;
  assign degenerate_o = degen_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rotation_matrix_to_quaternion_unit.sv =====
// Throughput: one matrix per cycle while the output is not stalled; every cell of the chain holds its own item.
// The chain is one front stage, FRACTION_BITS + 9 root cells, FRACTION_BITS + 18
// quotient cells and one output register.
// A stalled output lets empty cells upstream keep filling.
// Reset (rst_ni low, asynchronous) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit: rotation matrix to unit quaternion
// Four-branch trace method with a bit-serial root and divider cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_unit
  import rmq_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] r00_i,
  input  wire logic signed [15:0] r10_i,
  input  wire logic signed [15:0] r20_i,
  input  wire logic signed [15:0] r01_i,
  input  wire logic signed [15:0] r11_i,
  input  wire logic signed [15:0] r21_i,
  input  wire logic signed [15:0] r02_i,
  input  wire logic signed [15:0] r12_i,
  input  wire logic signed [15:0] r22_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      qx_o,
  output logic signed [15:0]      qy_o,
  output logic signed [15:0]      qz_o,
  output logic signed [15:0]      qw_o,
  output logic [1:0]              branch_o,
  output logic                    degenerate_o
);

  localparam int RT   = FRACTION_BITS + 9;
  localparam int NB   = FRACTION_BITS + 18;
  localparam int LAST = RT + NB + 1;

  logic [LAST:0] vld, en;

  // root chain, stage 0 is the front register
  rmq_item_t       sq_item [RT+1];
  logic [RT+1:0]   sq_rem  [RT+1];
  logic [RT-1:0]   sq_root [RT+1];
  logic [2*RT-1:0] sq_v    [RT+1];

  // quotient chain, stage 0 is formed from the last root stage
  rmq_item_t                         dv_item [NB+1];
  logic [RT-1:0]                     dv_root [NB+1];
  logic [NUM_LANES-1:0][RT+1:0]      dv_rem  [NB+1];
  logic [NUM_LANES-1:0][NB-1:0]      dv_n    [NB+1];
  logic [NUM_LANES-1:0][NB-1:0]      dv_q    [NB+1];

  // a cell takes a new item when empty or when its neighbor takes its item
  for (genvar s = 0; s < LAST; s++) begin : g_en
    assign en[s] = !vld[s] || en[s+1];
  end
  assign en[LAST]   = !vld[LAST] || !out_stall_i;
  assign in_stall_o = !en[0];

  rmq_front #(
    .FB (FRACTION_BITS),
    .RT (RT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en[0]),
    .valid_i (in_valid_i),
    .r00_i   (r00_i),
    .r10_i   (r10_i),
    .r20_i   (r20_i),
    .r01_i   (r01_i),
    .r11_i   (r11_i),
    .r21_i   (r21_i),
    .r02_i   (r02_i),
    .r12_i   (r12_i),
    .r22_i   (r22_i),
    .valid_o (vld[0]),
    .item_o  (sq_item[0]),
    .v_o     (sq_v[0])
  );

  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < RT; k++) begin : g_sqrt
    rmq_sqrt_cell #(
      .RT (RT)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[k+1]),
      .valid_i (vld[k]),
      .item_i  (sq_item[k]),
      .rem_i   (sq_rem[k]),
      .root_i  (sq_root[k]),
      .v_i     (sq_v[k]),
      .valid_o (vld[k+1]),
      .item_o  (sq_item[k+1]),
      .rem_o   (sq_rem[k+1]),
      .root_o  (sq_root[k+1]),
      .v_o     (sq_v[k+1])
    );
  end

  // numerator = magnitude in fixed point plus the root, for round to nearest
  assign dv_item[0] = sq_item[RT];
  assign dv_root[0] = sq_root[RT];
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      dv_rem[0][i] = '0;
      dv_q[0][i]   = '0;
      dv_n[0][i]   = (NB'(sq_item[RT].mag[i]) << FRACTION_BITS) + NB'(sq_root[RT]);
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_div
    rmq_div_cell #(
      .RT (RT),
      .NB (NB)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en[RT+1+j]),
      .valid_i (vld[RT+j]),
      .item_i  (dv_item[j]),
      .root_i  (dv_root[j]),
      .rem_i   (dv_rem[j]),
      .n_i     (dv_n[j]),
      .q_i     (dv_q[j]),
      .valid_o (vld[RT+1+j]),
      .item_o  (dv_item[j+1]),
      .root_o  (dv_root[j+1]),
      .rem_o   (dv_rem[j+1]),
      .n_o     (dv_n[j+1]),
      .q_o     (dv_q[j+1])
    );
  end

  rmq_back #(
    .RT (RT),
    .NB (NB)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en[LAST]),
    .valid_i      (vld[LAST-1]),
    .item_i       (dv_item[NB]),
    .root_i       (dv_root[NB]),
    .q_i          (dv_q[NB]),
    .valid_o      (vld[LAST]),
    .qx_o         (qx_o),
    .qy_o         (qy_o),
    .qz_o         (qz_o),
    .qw_o         (qw_o),
    .branch_o     (branch_o),
    .degenerate_o (degenerate_o)
  );

  assign out_valid_o = vld[LAST];

endmodule

`default_nettype wire

// ===== hw/rtl/rmq_checker.sv =====
// ----------------------------------------------------------------------------
// rmq_checker: port level checks for the quaternion unit
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_checker
  import rmq_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [15:0] qx_o,
  input wire logic [15:0] qy_o,
  input wire logic [15:0] qz_o,
  input wire logic [15:0] qw_o,
  input wire logic [1:0]  branch_o,
  input wire logic        degenerate_o
);

  // a stalled result holds its valid, qx, qw, branch and degenerate flag
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(qx_o) && $stable(qw_o)
      && $stable(branch_o) && $stable(degenerate_o))
    else $error("result changed while stalled");

  // a degenerate result carries zero components
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      qx_o == '0 && qy_o == '0 && qz_o == '0 && qw_o == '0)
    else $error("degenerate result with nonzero component");

  // the trace branch never degenerates
  a_trace_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> branch_o != BR_TRACE)
    else $error("degenerate result on trace branch");

  // the diagonal term of the trace branch is never negative
  a_w_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && branch_o == BR_TRACE |-> !qw_o[15])
    else $error("negative scalar part on trace branch");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .qx_o         (qx_o),
  .qy_o         (qy_o),
  .qz_o         (qz_o),
  .qw_o         (qw_o),
  .branch_o     (branch_o),
  .degenerate_o (degenerate_o)
);

`default_nettype wire
